>>> rtl/ctca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctca_pkg
// Shared types and constants of the CPU time counter accumulator.
// ----------------------------------------------------------------------------
package ctca_pkg;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [19:0] USEC_MAX     = 20'd999999;

  typedef enum logic [2:0] {
    ACT_CLEAR     = 3'd0,
    ACT_TIME_BEG  = 3'd1,
    ACT_TIME_END  = 3'd2,
    ACT_SNAP_BEG  = 3'd3,
    ACT_SNAP_END  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    KIND_INTERVAL = 3'd0,
    KIND_ELAPSED  = 3'd1,
    KIND_CPU_DLT  = 3'd2,
    KIND_CPU_TOT  = 3'd3,
    KIND_SYS_TOT  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_CALC,
    ST_ACC,
    ST_EMIT
  } state_e;

  // Five raw counters, and six accumulated values.
  typedef struct packed {
    logic [63:0] cal;
    logic [63:0] idle;
    logic [63:0] user;
    logic [63:0] kern;
    logic [63:0] intr;
  } cnt5_t;

  typedef struct packed {
    logic [63:0] cal;
    logic [63:0] idle;
    logic [63:0] user;
    logic [63:0] kern;
    logic [63:0] intr;
    logic [63:0] other;
  } cnt6_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  cpu_index;
    logic [31:0] stamp_sec;
    logic [19:0] stamp_usec;
    cnt5_t       cnt;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  out_cpu;
    logic [31:0] out_sec;
    logic [19:0] out_usec;
    cnt6_t       val;
    logic        last;
  } out_item_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic       capture;   // latch the input item
    logic       clr_regs;  // zero scalar stores
    logic       clr_wr;    // write zero to memories at clr_addr
    logic       time_beg;
    logic       time_end;
    logic       snap_beg;  // write base memory
    logic       mem_rd;    // read memories for captured cpu
    logic       calc;      // compute raw deltas and their subtotal
    logic       acc;       // compute other share and totals, write the totals memory
    kind_e      emit_sel;  // which result is shown
    logic       emit_load; // load output register
  } cmd_t;

endpackage

>>> rtl/ctca_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctca_if
// Valid/ready channel carrying one item.
// ----------------------------------------------------------------------------
interface ctca_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ctca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctca_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ctca_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Read before write: the registered read returns the old contents on a write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> rtl/ctca_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctca_ctrl
// Sequencer: decodes items, sweeps memories on clear, orders results.
// ----------------------------------------------------------------------------
module ctca_ctrl import ctca_pkg::*; #(
  parameter int CPU_COUNT = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] action_i,
  input  logic       cpu_ok_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output cmd_t       cmd_o,
  output logic [$clog2(CPU_COUNT)-1:0] clr_addr_o
);
  localparam int AW = $clog2(CPU_COUNT);
  localparam logic [AW:0] LAST_ADDR = (AW+1)'(CPU_COUNT - 1);

  state_e      state_q, state_d;
  logic [AW:0] clr_q, clr_d;
  kind_e       sel_q, sel_d;
  logic [1:0]  nres_q, nres_d;
  logic        ov_q, ov_d;

  assign clr_addr_o = clr_q[AW-1:0];
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      sel_q   <= KIND_INTERVAL;
      nres_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sel_q   <= sel_d;
      nres_q  <= nres_d;
      ov_q    <= ov_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    sel_d   = sel_q;
    nres_d  = nres_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    cmd_o.emit_sel = sel_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (action_i)
            ACT_CLEAR: begin
              cmd_o.clr_regs = 1'b1;
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            ACT_TIME_BEG: cmd_o.time_beg = 1'b1;
            ACT_TIME_END: begin
              cmd_o.time_end = 1'b1;
              sel_d  = KIND_INTERVAL;
              nres_d = 2'd1;
              state_d = ST_EMIT;
            end
            ACT_SNAP_BEG: cmd_o.snap_beg = cpu_ok_i;
            ACT_SNAP_END: begin
              if (cpu_ok_i) begin
                cmd_o.mem_rd = 1'b1;
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        clr_d = clr_q + (AW+1)'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        sel_d  = KIND_CPU_DLT;
        nres_d = 2'd2;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // Load the next result whenever the output register is free.
        if (!ov_q || out_ready_i) begin
          cmd_o.emit_load = 1'b1;
          ov_d = 1'b1;
          if (nres_q == 2'd0) begin
            state_d = ST_IDLE;
          end else begin
            nres_d = nres_q - 2'd1;
            sel_d  = kind_e'(sel_q + 3'd1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (ov_q && out_ready_i && !cmd_o.emit_load) begin
      ov_d = 1'b0;
    end
  end
endmodule

>>> rtl/ctca_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctca_dp
// Datapath: timestamp arithmetic, counter memories and result register.
// ----------------------------------------------------------------------------
module ctca_dp import ctca_pkg::*; #(
  parameter int CPU_COUNT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic [$clog2(CPU_COUNT)-1:0] clr_addr_i,
  input  in_item_t  in_i,
  output out_item_t out_o
);
  localparam int AW = $clog2(CPU_COUNT);

  in_item_t    it_q;
  logic [31:0] beg_sec_q, ela_sec_q, ds_q;
  logic [19:0] beg_usec_q, ela_usec_q, du_q;
  cnt6_t       sys_q, dlt_q, tot_q;
  logic [63:0] sub_q;
  out_item_t   out_q, res_d;

  // Saturated microseconds of the incoming item.
  logic [19:0] cu;
  assign cu = (in_i.stamp_usec > USEC_MAX) ? USEC_MAX : in_i.stamp_usec;

  // Interval with borrow, then elapsed with carry.
  logic [31:0] ds, es;
  logic [19:0] du;
  logic [20:0] eu;
  always_comb begin
    if (cu < beg_usec_q) begin
      du = cu + USEC_PER_SEC - beg_usec_q;
      ds = in_i.stamp_sec - beg_sec_q - 32'd1;
    end else begin
      du = cu - beg_usec_q;
      ds = in_i.stamp_sec - beg_sec_q;
    end
    eu = {1'b0, ela_usec_q} + {1'b0, du};
    es = ela_sec_q + ds;
    if (eu >= {1'b0, USEC_PER_SEC}) begin
      eu = eu - {1'b0, USEC_PER_SEC};
      es = es + 32'd1;
    end
  end

  // Memories: base counters and per-CPU totals.
  logic [AW-1:0] addr;
  logic          base_we, sum_we;
  cnt5_t         base_wd, base_rd;
  cnt6_t         sum_wd, sum_rd, d, dn, t;
  logic [63:0]   sub, other;

  assign addr = cmd_i.clr_wr ? clr_addr_i
              : (cmd_i.capture ? AW'(in_i.cpu_index) : AW'(it_q.cpu_index));
  assign base_we = cmd_i.clr_wr | cmd_i.snap_beg;
  assign base_wd = cmd_i.clr_wr ? '0 : in_i.cnt;
  assign sum_we  = cmd_i.clr_wr | cmd_i.acc;
  assign sum_wd  = cmd_i.clr_wr ? '0 : t;

  ctca_ram #(.WIDTH($bits(cnt5_t)), .DEPTH(CPU_COUNT)) u_base (
    .clk_i(clk_i), .we_i(base_we), .addr_i(addr), .wdata_i(base_wd), .rdata_o(base_rd)
  );
  ctca_ram #(.WIDTH($bits(cnt6_t)), .DEPTH(CPU_COUNT)) u_sum (
    .clk_i(clk_i), .we_i(sum_we), .addr_i(addr), .wdata_i(sum_wd), .rdata_o(sum_rd)
  );

  // First step: raw deltas and their subtotal.
  always_comb begin
    d.cal   = it_q.cnt.cal  - base_rd.cal;
    d.idle  = it_q.cnt.idle - base_rd.idle;
    d.user  = it_q.cnt.user - base_rd.user;
    d.kern  = it_q.cnt.kern - base_rd.kern;
    d.intr  = it_q.cnt.intr - base_rd.intr;
    d.other = '0;
    sub     = d.idle + d.user + d.kern + d.intr;
  end

  // Second step: other share, clamped at zero, and new totals.
  always_comb begin
    other    = (sub_q > dlt_q.cal) ? 64'd0 : dlt_q.cal - sub_q;
    dn       = dlt_q;
    dn.other = other;
    t.cal    = sum_rd.cal   + dn.cal;
    t.idle   = sum_rd.idle  + dn.idle;
    t.user   = sum_rd.user  + dn.user;
    t.kern   = sum_rd.kern  + dn.kern;
    t.intr   = sum_rd.intr  + dn.intr;
    t.other  = sum_rd.other + dn.other;
  end

  // Captured item and computed values.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      it_q <= in_i;
      ds_q <= ds;
      du_q <= du;
    end
    if (cmd_i.calc) begin
      dlt_q <= d;
      sub_q <= sub;
    end
    if (cmd_i.acc) begin
      dlt_q <= dn;
      tot_q <= t;
    end
  end

  // Scalar stores.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beg_sec_q  <= '0;
      beg_usec_q <= '0;
      ela_sec_q  <= '0;
      ela_usec_q <= '0;
      sys_q      <= '0;
    end else if (cmd_i.clr_regs) begin
      beg_sec_q  <= '0;
      beg_usec_q <= '0;
      ela_sec_q  <= '0;
      ela_usec_q <= '0;
      sys_q      <= '0;
    end else begin
      if (cmd_i.time_beg) begin
        beg_sec_q  <= in_i.stamp_sec;
        beg_usec_q <= cu;
      end
      if (cmd_i.time_end) begin
        ela_sec_q  <= es;
        ela_usec_q <= eu[19:0];
      end
      if (cmd_i.acc) begin
        sys_q.cal   <= sys_q.cal   + dn.cal;
        sys_q.idle  <= sys_q.idle  + dn.idle;
        sys_q.user  <= sys_q.user  + dn.user;
        sys_q.kern  <= sys_q.kern  + dn.kern;
        sys_q.intr  <= sys_q.intr  + dn.intr;
        sys_q.other <= sys_q.other + dn.other;
      end
    end
  end

  // Select the result to show next.
  always_comb begin
    res_d = '0;
    case (cmd_i.emit_sel)
      KIND_INTERVAL: begin
        res_d.kind     = KIND_INTERVAL;
        res_d.out_sec  = ds_q;
        res_d.out_usec = du_q;
      end
      KIND_ELAPSED: begin
        res_d.kind     = KIND_ELAPSED;
        res_d.out_sec  = ela_sec_q;
        res_d.out_usec = ela_usec_q;
        res_d.last     = 1'b1;
      end
      KIND_CPU_DLT: begin
        res_d.kind    = KIND_CPU_DLT;
        res_d.out_cpu = it_q.cpu_index;
        res_d.val     = dlt_q;
      end
      KIND_CPU_TOT: begin
        res_d.kind    = KIND_CPU_TOT;
        res_d.out_cpu = it_q.cpu_index;
        res_d.val     = tot_q;
      end
      KIND_SYS_TOT: begin
        res_d.kind = KIND_SYS_TOT;
        res_d.val  = sys_q;
        res_d.last = 1'b1;
      end
      default: ;
    endcase
  end

  // Result register, loaded one result at a time.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_q <= res_d;
    end
  end

  assign out_o = out_q;
endmodule

>>> rtl/cpu_time_counter_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_time_counter_accumulator
// Per-CPU time counter accumulator with interval timing.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in       in   action, cpu_index, stamp_sec, stamp_usec, five raw counters
// out      out  kind, out_cpu, out_sec, out_usec, six values, last
//
// Start, ignored and out-of-range items are taken in the idle state; a clear item
// is taken and then starts the sweep. An end-time item goes straight to the
// single result register; an end-snapshot item first passes the registered read
// of the per-CPU memories and the two-step delta and total arithmetic.
// Reset and clear sweep the memories, one entry a cycle, with no item accepted
// during the sweep. A stalled result holds the sequencer in place.
// ----------------------------------------------------------------------------
module cpu_time_counter_accumulator import ctca_pkg::*; #(
  parameter int CPU_COUNT = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ctca_if.sink   in_if,
  ctca_if.source out_if
);
  localparam int AW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int CC = (CPU_COUNT > 1) ? CPU_COUNT : 2;

  cmd_t          cmd;
  logic [AW-1:0] clr_addr;
  in_item_t      it;
  out_item_t     res;
  logic          cpu_ok;

  assign it = in_if.data;

  // Snapshot items for a processor index of CPU_COUNT or above are dropped.
  assign cpu_ok = ({5'd0, it.cpu_index} < 9'(CPU_COUNT));

  ctca_ctrl #(.CPU_COUNT(CC)) u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .action_i(it.action), .cpu_ok_i(cpu_ok),
    .out_ready_i(out_if.ready), .out_valid_o(out_if.valid),
    .cmd_o(cmd), .clr_addr_o(clr_addr)
  );

  ctca_dp #(.CPU_COUNT(CC)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .clr_addr_i(clr_addr),
    .in_i(it), .out_o(res)
  );

  assign out_if.data = res;

  // Assertions.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> out_if.valid) else $error("result dropped");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |=> $stable(out_if.data)) else $error("result changed");
  a_usec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.data.out_usec < USEC_PER_SEC) else $error("usec range");
endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the CPU time counter accumulator against an in-bench predictor.
// Directed items cover clear, time and snapshot actions at field extremes,
// ignored items and saturated microseconds. Random items then run mostly
// well-formed start/end pairs, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

// Predictor of the block, with a store of the results still awaited.
class counter_scoreboard;
  ctca_pkg::out_item_t awaited[$];
  int unsigned errors;
  int unsigned results_seen;
  logic [31:0] beg_sec, ela_sec;
  logic [19:0] beg_usec, ela_usec;
  ctca_pkg::cnt5_t base[16];
  ctca_pkg::cnt6_t cpu_tot[16];
  ctca_pkg::cnt6_t sys_tot;

  function new();
    wipe();
  endfunction

  function void wipe();
    beg_sec = '0; beg_usec = '0; ela_sec = '0; ela_usec = '0;
    sys_tot = '0;
    for (int i = 0; i < 16; i++) begin
      base[i] = '0;
      cpu_tot[i] = '0;
    end
  endfunction

  function logic [19:0] clamp_usec(logic [19:0] u);
    return (u > ctca_pkg::USEC_MAX) ? ctca_pkg::USEC_MAX : u;
  endfunction

  // Note an accepted input item and queue the results it causes.
  function void note_input(ctca_pkg::in_item_t it);
    ctca_pkg::out_item_t r;
    ctca_pkg::cnt6_t d;
    logic [31:0] ds;
    logic [19:0] cu, du;
    logic [20:0] eu;
    logic [63:0] sub;
    int c;
    c = it.cpu_index;
    case (it.action)
      ctca_pkg::ACT_CLEAR: wipe();
      ctca_pkg::ACT_TIME_BEG: begin
        beg_sec = it.stamp_sec;
        beg_usec = clamp_usec(it.stamp_usec);
      end
      ctca_pkg::ACT_TIME_END: begin
        cu = clamp_usec(it.stamp_usec);
        ds = it.stamp_sec - beg_sec;
        if (cu < beg_usec) begin
          du = cu + ctca_pkg::USEC_PER_SEC - beg_usec;
          ds = ds - 1;
        end else begin
          du = cu - beg_usec;
        end
        ela_sec = ela_sec + ds;
        eu = ela_usec + du;
        if (eu >= ctca_pkg::USEC_PER_SEC) begin
          eu = eu - ctca_pkg::USEC_PER_SEC;
          ela_sec = ela_sec + 1;
        end
        ela_usec = eu[19:0];
        r = '0;
        r.kind = ctca_pkg::KIND_INTERVAL; r.out_sec = ds; r.out_usec = du;
        awaited.push_back(r);
        r.kind = ctca_pkg::KIND_ELAPSED; r.out_sec = ela_sec; r.out_usec = ela_usec;
        r.last = 1'b1;
        awaited.push_back(r);
      end
      ctca_pkg::ACT_SNAP_BEG: base[c] = it.cnt;
      ctca_pkg::ACT_SNAP_END: begin
        d.cal = it.cnt.cal - base[c].cal;
        d.idle = it.cnt.idle - base[c].idle;
        d.user = it.cnt.user - base[c].user;
        d.kern = it.cnt.kern - base[c].kern;
        d.intr = it.cnt.intr - base[c].intr;
        sub = d.idle + d.user + d.kern + d.intr;
        d.other = (sub > d.cal) ? 64'd0 : d.cal - sub;
        cpu_tot[c].cal += d.cal; cpu_tot[c].idle += d.idle;
        cpu_tot[c].user += d.user; cpu_tot[c].kern += d.kern;
        cpu_tot[c].intr += d.intr; cpu_tot[c].other += d.other;
        sys_tot.cal += d.cal; sys_tot.idle += d.idle; sys_tot.user += d.user;
        sys_tot.kern += d.kern; sys_tot.intr += d.intr; sys_tot.other += d.other;
        r = '0;
        r.kind = ctca_pkg::KIND_CPU_DLT; r.out_cpu = it.cpu_index; r.val = d;
        awaited.push_back(r);
        r.kind = ctca_pkg::KIND_CPU_TOT; r.val = cpu_tot[c];
        awaited.push_back(r);
        r.kind = ctca_pkg::KIND_SYS_TOT; r.out_cpu = '0; r.val = sys_tot; r.last = 1'b1;
        awaited.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function void field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Compare one accepted result with the oldest awaited one.
  function void check_result(ctca_pkg::out_item_t got);
    ctca_pkg::out_item_t e;
    results_seen++;
    if (awaited.size() == 0) begin
      $error("unexpected result, kind %0d", got.kind);
      errors++;
      return;
    end
    e = awaited.pop_front();
    field("kind", e.kind, got.kind);
    field("out_cpu", e.out_cpu, got.out_cpu);
    field("out_sec", e.out_sec, got.out_sec);
    field("out_usec", e.out_usec, got.out_usec);
    field("val_calibrate", e.val.cal, got.val.cal);
    field("val_idle", e.val.idle, got.val.idle);
    field("val_user", e.val.user, got.val.user);
    field("val_kernel", e.val.kern, got.val.kern);
    field("val_interrupt", e.val.intr, got.val.intr);
    field("val_other", e.val.other, got.val.other);
    field("last", e.last, got.last);
  endfunction
endclass

module tb;
  import ctca_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  bit sending_done = 1'b0;
  bit hold_off = 1'b0;

  ctca_if #(.T(in_item_t)) in_if ();
  ctca_if #(.T(out_item_t)) out_if ();

  counter_scoreboard board = new();

  cpu_time_counter_accumulator #(.CPU_COUNT(16)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  // Clock, 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check accepted items, stall at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) board.check_result(out_if.data);
      if (hold_off) out_if.ready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_if.ready <= 1'b0;
      else out_if.ready <= 1'b1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one item and wait until it is accepted.
  task automatic send_item(in_item_t it, int unsigned gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_input(it);
    items_sent++;
  endtask

  function automatic in_item_t make_item(action_e a, logic [3:0] c);
    in_item_t it;
    it.action = a;
    it.cpu_index = c;
    it.stamp_sec = $urandom();
    it.stamp_usec = ($urandom_range(0, 9) == 0) ? 20'($urandom())
                                                : 20'($urandom_range(0, 999999));
    it.cnt.cal = rand64(); it.cnt.idle = rand64(); it.cnt.user = rand64();
    it.cnt.kern = rand64(); it.cnt.intr = rand64();
    return it;
  endfunction

  // Long receiver stall while the sender keeps offering.
  initial begin
    wait (items_sent >= 120);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    in_item_t it;
    int unsigned drain;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part.
    it = '0; it.action = ACT_TIME_END; send_item(it, 0);      // end without start
    it = '1; it.action = ACT_SNAP_END; it.cpu_index = 4'd15; send_item(it, 0);
    it = '1; it.action = ACT_TIME_BEG; send_item(it, 0);      // usec saturates
    it = '0; it.action = ACT_TIME_END; it.stamp_usec = 20'd5; send_item(it, 1);
    it = '1; it.action = ACT_SNAP_BEG; it.cpu_index = 4'd0; send_item(it, 0);
    it = '0; it.action = ACT_SNAP_END; it.cpu_index = 4'd0; send_item(it, 0);
    it = '0; it.action = ACT_SNAP_BEG; it.cpu_index = 4'd3; send_item(it, 0);
    it = '0; it.action = ACT_SNAP_END; it.cpu_index = 4'd3; it.cnt.cal = 64'd100;
    it.cnt.idle = 64'd10; it.cnt.user = 64'd20; it.cnt.kern = 64'd30;
    it.cnt.intr = 64'd40; send_item(it, 2);
    it.cnt.cal = 64'd50; send_item(it, 0);                     // subtotal exceeds calibrate
    it = '1; it.action = action_e'(3'd5); send_item(it, 0);    // unused codes
    it.action = action_e'(3'd6); send_item(it, 0);
    it.action = action_e'(3'd7); send_item(it, 0);
    it = '0; it.action = ACT_TIME_BEG; it.stamp_usec = 20'd999999; send_item(it, 0);
    it.action = ACT_TIME_END; it.stamp_sec = 32'd1; it.stamp_usec = 20'd999998;
    send_item(it, 0);
    it.stamp_usec = 20'd999999; send_item(it, 0);
    it = make_item(ACT_CLEAR, 4'd0); send_item(it, 0);
    it = make_item(ACT_SNAP_END, 4'd7); send_item(it, 0);

    // Random part: mostly start/end pairs, some noise.
    while (items_sent < 310) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 1)) begin
          it = make_item(ACT_TIME_BEG, 4'($urandom()));
          send_item(it, pick_gap());
          it = make_item(ACT_TIME_END, 4'($urandom()));
        end else begin
          it = make_item(ACT_SNAP_BEG, 4'($urandom()));
          send_item(it, pick_gap());
          it.action = ACT_SNAP_END;
          if ($urandom_range(0, 3) != 0) begin
            it.cnt.cal = it.cnt.cal + {$urandom(), 4'h0};
            it.cnt.idle = it.cnt.idle + 64'($urandom_range(0, 4000));
            it.cnt.user = it.cnt.user + 64'($urandom_range(0, 4000));
            it.cnt.kern = it.cnt.kern + 64'($urandom_range(0, 4000));
            it.cnt.intr = it.cnt.intr + 64'($urandom_range(0, 4000));
          end else begin
            it = make_item(ACT_SNAP_END, it.cpu_index);
          end
        end
        send_item(it, pick_gap());
      end else begin
        it = make_item(action_e'($urandom_range(0, 7)), 4'($urandom()));
        if (it.action == ACT_CLEAR && $urandom_range(0, 3) != 0) it.action = ACT_TIME_END;
        send_item(it, pick_gap());
      end
    end
    in_if.valid <= 1'b0;

    drain = 0;
    while (board.awaited.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (30) @(posedge clk_i);
    if (board.awaited.size() != 0) begin
      $error("%0d results never arrived", board.awaited.size());
      board.errors++;
    end
    $display("Run covered %0d input items and %0d checked results,", items_sent,
             board.results_seen);
    $display("including clear, ignored codes, saturated usec and a long output stall.");
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/ctca_pkg.sv
rtl/ctca_if.sv
rtl/ctca_ram.sv
rtl/ctca_ctrl.sv
rtl/ctca_dp.sv
rtl/cpu_time_counter_accumulator.sv
bench/tb.sv
